[hw/rtl/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

    // Default sizes
    localparam int SFR_MAX_FIND    = 8;
    localparam int SFR_MAX_REPLACE = 8;
    localparam int SFR_QUEUE_DEPTH = 4;

    // Pattern registers are fixed at eight bytes
    localparam int PAT_BYTES = 8;
    localparam int PAT_W     = PAT_BYTES * 8;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_PATTERN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH  = 2'd3;

    // Input kinds
    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // One queued burst: up to eight bytes, first byte in bits 7:0
    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic [PAT_W-1:0] bytes;
    } sfr_entry_t;

endpackage

`default_nettype wire

[hw/rtl/sfr_front.sv]
`default_nettype none

module sfr_front
    import sfr_pkg::*;
#(
    parameter int MAX_FIND    = SFR_MAX_FIND,
    parameter int MAX_REPLACE = SFR_MAX_REPLACE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0]     cfg_data,
    // input request
    input  wire logic                 in_take,
    input  wire logic                 kind,
    input  wire logic [7:0]           data_byte,
    // to queue
    output logic                      push,
    output sfr_entry_t                push_entry
);

    localparam int HCW = $clog2(MAX_FIND + 1);

    logic [PAT_W-1:0] find_pattern_reg;
    logic [LEN_W-1:0] find_length_reg;
    logic [PAT_W-1:0] replace_pattern_reg;
    logic [LEN_W-1:0] replace_length_reg;

    logic [7:0]       held_reg [MAX_FIND];
    logic [HCW-1:0]   held_count_reg;
    logic [HCW-1:0]   held_count_next;

    logic [LEN_W-1:0] flen;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] total;
    logic [7:0]       win [MAX_FIND];
    logic [PAT_W-1:0] win_vec;
    logic             hit;
    logic             shift;
    sfr_entry_t       entry;

    // Effective lengths, clamped to the hardware size
    assign flen = (find_length_reg > LEN_W'(MAX_FIND)) ? LEN_W'(MAX_FIND) : find_length_reg;
    assign rlen = (replace_length_reg > LEN_W'(MAX_REPLACE)) ?
                  LEN_W'(MAX_REPLACE) : replace_length_reg;
    assign total = LEN_W'(held_count_reg) + LEN_W'(1);

    // Window: held bytes with the new byte dropped in behind them
    always_comb
    begin
        win_vec = '0;
        for (int k = 0; k < MAX_FIND; k++)
        begin
            win[k] = (held_count_reg == HCW'(k)) ? data_byte : held_reg[k];
            win_vec[8*k +: 8] = win[k];
        end
    end

    // Compare the window against the find string
    always_comb
    begin
        hit = 1'b1;
        for (int k = 0; k < MAX_FIND; k++)
        begin
            if ((LEN_W'(k) < flen) && (win[k] != find_pattern_reg[8*k +: 8]))
                hit = 1'b0;
        end
    end

    // Classify the request into a burst and the new hold
    always_comb
    begin
        entry           = '0;
        held_count_next = held_count_reg;
        shift           = 1'b0;
        if (kind == KIND_FLUSH)
        begin
            entry.bytes     = win_vec;
            entry.count     = LEN_W'(held_count_reg);
            held_count_next = '0;
        end
        else if (flen == '0)
        begin
            entry.bytes     = win_vec;
            entry.count     = total;
            held_count_next = '0;
        end
        else if (total < flen)
        begin
            held_count_next = HCW'(total);
        end
        else if (hit)
        begin
            entry.bytes     = replace_pattern_reg;
            entry.count     = rlen;
            held_count_next = '0;
        end
        else
        begin
            // release oldest byte, window slides by one
            entry.bytes[7:0] = win[0];
            entry.count      = LEN_W'(1);
            shift            = 1'b1;
        end
    end

    assign push       = in_take && (entry.count != '0);
    assign push_entry = entry;

    // Config registers and hold count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            find_pattern_reg    <= '0;
            find_length_reg     <= '0;
            replace_pattern_reg <= '0;
            replace_length_reg  <= '0;
            held_count_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIND_PATTERN:    find_pattern_reg <= cfg_data;
                CFG_FIND_LENGTH:
                begin
                    find_length_reg <= cfg_data[LEN_W-1:0];
                    held_count_reg  <= '0;
                end
                CFG_REPLACE_PATTERN: replace_pattern_reg <= cfg_data;
                CFG_REPLACE_LENGTH:  replace_length_reg <= cfg_data[LEN_W-1:0];
                default:             ;
            endcase
        end
        else if (in_take)
        begin
            held_count_reg <= held_count_next;
        end
    end

    // Held bytes: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (in_take && (kind == KIND_DATA))
        begin
            for (int k = 0; k < MAX_FIND - 1; k++)
                held_reg[k] <= shift ? win[k+1] : win[k];
            held_reg[MAX_FIND-1] <= win[MAX_FIND-1];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sfr_queue.sv]
`default_nettype none

module sfr_queue
    import sfr_pkg::*;
#(
    parameter int DEPTH = SFR_QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire sfr_entry_t push_entry,
    input  wire logic       pop,
    output logic            full,
    output logic            not_empty,
    output sfr_entry_t      head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sfr_entry_t     slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

[hw/rtl/sfr_back.sv]
`default_nettype none

module sfr_back
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_not_empty,
    input  wire sfr_entry_t q_head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            last
);

    sfr_entry_t  cur_reg;
    logic        cur_valid_reg;
    logic [2:0]  pos_reg;
    logic        sent;
    logic        take;

    assign out_valid = cur_valid_reg;
    assign out_byte  = cur_reg.bytes[{pos_reg, 3'b000} +: 8];
    assign last      = (LEN_W'(pos_reg) + LEN_W'(1)) == cur_reg.count;
    assign sent      = cur_valid_reg && !out_stall;

    // Load the next burst when idle or when the final byte leaves
    assign take = !cur_valid_reg || (sent && last);
    assign pop  = take && q_not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else if (take)
        begin
            cur_valid_reg <= q_not_empty;
            pos_reg       <= '0;
        end
        else if (sent)
        begin
            pos_reg <= pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= q_head;
    end

endmodule

`default_nettype wire

[hw/rtl/stream_find_replace.sv]
// Channel  | Dir | Handshake            | Payload
// input    | in  | in_valid / in_stall  | kind, data_byte
// output   | out | out_valid / out_stall| out_byte, last
// config   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request is taken per cycle while in_stall is low; its result bytes
// leave one per cycle while out_stall is low. A match with an N-byte replacement
// or a flush of N held bytes gives N output bytes; the output drainer sets the
// sustained rate. in_stall rises only when the burst queue (QUEUE_DEPTH entries)
// is full. Reset clears config, the hold count, the queue and the output stage.
// cfg_ready is always high; the user must make writes while the block is idle (unchecked).
`default_nettype none

module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_FIND    = SFR_MAX_FIND,
    parameter int MAX_REPLACE = SFR_MAX_REPLACE,
    parameter int QUEUE_DEPTH = SFR_QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0]     cfg_data,
    // input stream
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 kind,
    input  wire logic [7:0]           data_byte,
    // output stream
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      last
);

    logic       in_take;
    logic       push;
    sfr_entry_t push_entry;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    sfr_entry_t q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_take   = in_valid && !q_full;

    sfr_front #(
        .MAX_FIND    (MAX_FIND),
        .MAX_REPLACE (MAX_REPLACE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_take    (in_take),
        .kind       (kind),
        .data_byte  (data_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    sfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    sfr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

endmodule

`default_nettype wire

[hw/rtl/sfr_checker.sv]
`default_nettype none

module sfr_checker
    import sfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [7:0] out_byte,
    input  wire logic       last
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("output changed while stalled");

    // Input backpressure only while the output side is busy
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with output idle");

    // A burst continues without gaps until its last byte
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("burst broken before last byte");

    // Nothing waits on the input side right after reset
    a_reset_free: assert property (@(posedge clk)
        !rst_n |=> !in_stall)
        else $error("input stalled after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

`default_nettype wire

[dv/sfr_rewrite_checker.sv]
`default_nettype none

module sfr_rewrite_checker
    import sfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PAT_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 kind,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [7:0]           out_byte,
    input  wire logic                 last,
    output int                        errors,
    output int                        pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } rewritten_t;

    // Shadow copy of the rewrite rule and of the hold-back window
    logic [PAT_W-1:0] find_pat  = '0;
    logic [LEN_W-1:0] find_len  = '0;
    logic [PAT_W-1:0] repl_pat  = '0;
    logic [LEN_W-1:0] repl_len  = '0;
    logic [7:0]       hold_buf [SFR_MAX_FIND];
    int               hold_cnt  = 0;

    rewritten_t rewritten_q[$];
    int         mismatch_count = 0;

    // Work out the bytes one accepted request releases, tagging the final one
    task automatic predict_rewrite(input logic req_kind, input logic [7:0] req_byte);
        int         flen;
        int         rlen;
        logic       hit;
        logic [7:0] burst[$];
        flen = (find_len > SFR_MAX_FIND) ? SFR_MAX_FIND : int'(find_len);
        rlen = (repl_len > SFR_MAX_REPLACE) ? SFR_MAX_REPLACE : int'(repl_len);
        if (req_kind == KIND_FLUSH || flen == 0)
        begin
            // flush, or pass through: release the held bytes as they are
            for (int k = 0; k < hold_cnt; k++)
                burst.push_back(hold_buf[k]);
            hold_cnt = 0;
            if (req_kind != KIND_FLUSH)
                burst.push_back(req_byte);
        end
        else
        begin
            hold_buf[hold_cnt] = req_byte;
            hold_cnt++;
            if (hold_cnt >= flen)
            begin
                hit = 1'b1;
                for (int k = 0; k < flen; k++)
                    if (hold_buf[k] != find_pat[8*k +: 8])
                        hit = 1'b0;
                if (hit)
                begin
                    for (int k = 0; k < rlen; k++)
                        burst.push_back(repl_pat[8*k +: 8]);
                    hold_cnt = 0;
                end
                else
                begin
                    // window missed: only the oldest byte leaves
                    burst.push_back(hold_buf[0]);
                    for (int k = 1; k < hold_cnt; k++)
                        hold_buf[k-1] = hold_buf[k];
                    hold_cnt--;
                end
            end
        end
        foreach (burst[k])
            rewritten_q.push_back('{out_byte: burst[k], last: (k == burst.size() - 1)});
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIND_PATTERN:    find_pat = cfg_data;
                    CFG_FIND_LENGTH:
                    begin
                        find_len = cfg_data[LEN_W-1:0];
                        hold_cnt = 0;
                    end
                    CFG_REPLACE_PATTERN: repl_pat = cfg_data;
                    CFG_REPLACE_LENGTH:  repl_len = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // accepted request
            if (in_valid && !in_stall)
                predict_rewrite(kind, data_byte);

            // accepted result byte against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (rewritten_q.size() == 0)
                begin
                    $display("%0t unexpected result: out_byte %02h last %0b",
                             $time, out_byte, last);
                    mismatch_count++;
                end
                else
                begin
                    if (out_byte !== rewritten_q[0].out_byte)
                    begin
                        $display("%0t out_byte mismatch: expected %02h, actual %02h",
                                 $time, rewritten_q[0].out_byte, out_byte);
                        mismatch_count++;
                    end
                    if (last !== rewritten_q[0].last)
                    begin
                        $display("%0t last mismatch: expected %0b, actual %0b",
                                 $time, rewritten_q[0].last, last);
                        mismatch_count++;
                    end
                    void'(rewritten_q.pop_front());
                end
            end
        end
        errors  <= mismatch_count;
        pending <= rewritten_q.size();
    end

endmodule

`default_nettype wire

[dv/tb_stream_find_replace.sv]
`default_nettype none

module tb_stream_find_replace;
    import sfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 120;
    localparam int TIMEOUT_NS    = 3_000_000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PAT_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 kind      = KIND_DATA;
    logic [7:0]           data_byte = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_ready;
    logic                 in_stall;
    logic                 out_valid;
    logic [7:0]           out_byte;
    logic                 last;

    int errors;
    int pending;

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    bit hold_request = 1'b0;
    int items_sent   = 0;

    // rule currently loaded, as the request generator sees it
    logic [PAT_W-1:0] cur_find_pat = '0;
    int               cur_find_eff = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stream_find_replace dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    sfr_rewrite_checker rewrite_monitor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .errors    (errors),
        .pending   (pending)
    );

    // Output side: random stall, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offer one request, with random gaps, until it is taken
    task automatic send_item(input logic req_kind, input logic [7:0] req_byte);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= req_kind;
        data_byte <= req_byte;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Stop sending and wait until every expected byte is out
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_rule(input logic [PAT_W-1:0] fp, input logic [LEN_W-1:0] fl,
                             input logic [PAT_W-1:0] rp, input logic [LEN_W-1:0] rl);
        settle();
        write_reg(CFG_FIND_PATTERN, fp);
        write_reg(CFG_FIND_LENGTH, PAT_W'(fl));
        write_reg(CFG_REPLACE_PATTERN, rp);
        write_reg(CFG_REPLACE_LENGTH, PAT_W'(rl));
        cfg_valid    <= 1'b0;
        cur_find_pat  = fp;
        cur_find_eff  = (fl > SFR_MAX_FIND) ? SFR_MAX_FIND : int'(fl);
    endtask

    // Mostly whole find strings, some cut short, some noise and flushes
    task automatic send_fragment();
        int         pick;
        int         n;
        logic [7:0] noise;
        pick  = $urandom_range(9);
        noise = $urandom_range(1) ? cur_find_pat[8*$urandom_range(7) +: 8]
                                  : 8'($urandom_range(255));
        if (pick == 9)
            send_item(KIND_FLUSH, 8'($urandom_range(255)));
        else if (pick == 8 || cur_find_eff == 0)
            send_item(KIND_DATA, noise);
        else
        begin
            n = (pick < 6) ? cur_find_eff : $urandom_range(1, cur_find_eff);
            for (int k = 0; k < n; k++)
                send_item(KIND_DATA, cur_find_pat[8*k +: 8]);
        end
    endtask

    initial
    begin
        logic [PAT_W-1:0] fp;
        logic [PAT_W-1:0] rp;
        logic [LEN_W-1:0] fl;
        logic [LEN_W-1:0] rl;
        int               start;
        int               pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // pass through with reset settings, flush with nothing held
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_FLUSH, 8'h00);

        // "abc" -> "XY": a hit, a near miss, then flushes
        load_rule(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
        send_item(KIND_DATA, 8'h61);
        send_item(KIND_DATA, 8'h62);
        send_item(KIND_DATA, 8'h63);
        send_item(KIND_DATA, 8'h61);
        send_item(KIND_DATA, 8'h62);
        send_item(KIND_DATA, 8'h64);
        send_item(KIND_FLUSH, 8'hFF);
        send_item(KIND_FLUSH, 8'h00);

        // oversized lengths clamp to eight bytes; leave one byte held
        fp = 64'hFF00_5AA5_C33C_00FF;
        load_rule(fp, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF);
        for (int k = 0; k < 8; k++)
            send_item(KIND_DATA, fp[8*k +: 8]);
        send_item(KIND_DATA, fp[7:0]);

        // new find length drops that byte; empty replacement
        load_rule(64'h0, 4'd1, 64'h0, 4'd0);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_FLUSH, 8'hA5);

        // random rules under three idling profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 62 : 0;
            rx_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 25 : 0;
            for (int rule = 0; rule < 3; rule++)
            begin
                pick = $urandom_range(9);
                fl = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 :
                     (pick == 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 4));
                pick = $urandom_range(9);
                rl = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd8 :
                     (pick == 2) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(1, 5));
                fp = {$urandom, $urandom};
                rp = {$urandom, $urandom};
                // two-symbol find strings give overlapping partial matches
                if ($urandom_range(3) == 0)
                    for (int k = 2; k < 8; k++)
                        fp[8*k +: 8] = $urandom_range(1) ? fp[7:0] : fp[15:8];
                // short rule so every data request yields bytes while the output is held
                if (phase == 2 && rule == 0)
                begin
                    fl = 4'd1;
                    rl = 4'd3;
                end
                load_rule(fp, fl, rp, rl);
                if (phase == 2 && rule == 0)
                    hold_request = 1'b1;
                start = items_sent;
                while (items_sent - start < 8)
                    send_fragment();
                if (phase == 1 && rule == 1)
                    settle();
                while (items_sent - start < 16)
                    send_fragment();
            end
        end

        settle();
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace.sv
hw/rtl/sfr_checker.sv
dv/sfr_rewrite_checker.sv
dv/tb_stream_find_replace.sv
